FILE: sv/scc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and field layout for the strongly connected components block.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int VERT_W  = 9;
    localparam int OP_W    = 2;
    localparam int LABEL_W = 8;
    localparam int TOTAL_W = 9;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_RUN   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [12:0] {
        ST_IDLE     = 13'b0000000000001,
        ST_QUERY    = 13'b0000000000010,
        ST_P1_OUTER = 13'b0000000000100,
        ST_EDGE_RD  = 13'b0000000001000,
        ST_EDGE_CHK = 13'b0000000010000,
        ST_POP_LOAD = 13'b0000000100000,
        ST_P2_RD    = 13'b0000001000000,
        ST_P2_CHK   = 13'b0000010000000,
        ST_RN_RD    = 13'b0000100000000,
        ST_RN_MAP   = 13'b0001000000000,
        ST_RN_WR    = 13'b0010000000000,
        ST_DONE     = 13'b0100000000000,
        ST_SPARE    = 13'b1000000000000
    } t_state;

endpackage
`default_nettype wire

FILE: sv/scc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: sv/strongly_connected_components.sv
`default_nettype none
// ----------------------------------------------------------------------------
// strongly_connected_components
// Edge store plus Kosaraju component finder with query port.
// ----------------------------------------------------------------------------
// Usage:
//   Write vertex_count on the cfg channel (i_cfg_valid/o_cfg_ready/i_cfg_data)
//   while the block is idle. Send words on the slave stream: op 0 adds an
//   edge, op 1 runs the component search, op 2 queries one vertex. Every
//   input word yields exactly one output word on the master stream.
// Sequencing:
//   An add or a bad query returns its word the cycle after it is accepted;
//   a good query first reads the label RAM in the QUERY state. A run holds
//   s_tready low until it is done: every edge test is an edge RAM read and
//   check, rescanned from each stack frame, plus a renumber sweep (read, map,
//   write per live vertex) over all MAX_VERTICES slots.
// Reset:
//   Clears edge count, component total and the run flag; labels read as 0
//   until the first run. RAM contents are not cleared.
// Stall:
//   The result is held in an output register until m_tready; a new word is
//   taken only when that register is empty or draining in the same cycle.
// ----------------------------------------------------------------------------
module strongly_connected_components #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // cfg write: vertex_count
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [8:0]  i_cfg_data,
    // slave stream tdata: op[1:0], tail_vertex[10:2], head_vertex[19:11],
    // query_vertex[28:20], zero[31:29]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,
    // master stream tdata: component_id[7:0], component_total[16:8],
    // error_flag[17], zero[23:18]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata
);

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int DW  = AW + 1;
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int VW  = scc_pkg::VERT_W;
    localparam int LW  = scc_pkg::LABEL_W;
    localparam int TW  = scc_pkg::TOTAL_W;
    localparam int SW  = VW + EW;
    localparam logic [VW-1:0] VCLIP =
        (MAX_VERTICES > 511) ? VW'(511) : VW'(MAX_VERTICES);

    // input fields
    logic [1:0]    w_op;
    logic [VW-1:0] w_tail, w_head, w_qv;
    assign w_op   = s_tdata[1:0];
    assign w_tail = s_tdata[10:2];
    assign w_head = s_tdata[19:11];
    assign w_qv   = s_tdata[28:20];

    scc_pkg::t_state r_state, n_state;

    logic [VW-1:0]           r_vc;
    logic [EW-1:0]           r_edges;
    logic [TW-1:0]           r_total;
    logic                    r_ran;
    logic                    r_pass2;
    logic [VW:0]             r_i;
    logic [VW-1:0]           r_top_v;
    logic [EW-1:0]           r_top_j;
    logic [DW-1:0]           r_depth;
    logic [DW-1:0]           r_finished;
    logic [TW-1:0]           r_count;
    logic [TW-1:0]           r_next_id;
    logic [DW-1:0]           r_rn_i;
    logic [LW-1:0]           r_raw;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [MAX_VERTICES-1:0] r_renumd;

    logic          r_out_valid;
    logic [LW-1:0] r_out_id;
    logic [TW-1:0] r_out_total;
    logic          r_out_err;

    assign o_cfg_ready = 1'b1;
    assign m_tvalid    = r_out_valid;
    assign m_tdata     = {6'd0, r_out_err, r_out_total, r_out_id};

    logic w_out_free;
    assign w_out_free = !r_out_valid || m_tready;
    assign s_tready   = (r_state == scc_pkg::ST_IDLE) && w_out_free;

    logic w_accept;
    assign w_accept = s_tvalid && s_tready;

    // active vertex count
    logic [VW-1:0] w_n;
    assign w_n = (r_vc > VCLIP) ? VCLIP : r_vc;

    // RAM ports
    logic            e_we;  logic [EAW-1:0] e_waddr, e_raddr;
    logic [2*VW-1:0] e_wdata, e_rdata;
    logic            s_we;  logic [AW-1:0] s_waddr, s_raddr;
    logic [SW-1:0]   s_wdata, s_rdata;
    logic            f_we;  logic [AW-1:0] f_waddr, f_raddr;
    logic [VW-1:0]   f_wdata, f_rdata;
    logic            rw_we; logic [AW-1:0] rw_waddr, rw_raddr;
    logic [LW-1:0]   rw_wdata, rw_rdata;
    logic            m_we;  logic [AW-1:0] m_waddr, m_raddr;
    logic [LW-1:0]   m_wdata, m_rdata;
    logic            l_we;  logic [AW-1:0] l_waddr, l_raddr;
    logic [LW-1:0]   l_wdata, l_rdata;

    scc_ram #(.WIDTH(2*VW), .DEPTH(MAX_EDGES)) u_edges (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata));
    scc_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata));
    scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_finish (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata));
    scc_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_raw (
        .i_clk(i_clk), .i_we(rw_we), .i_waddr(rw_waddr), .i_wdata(rw_wdata),
        .i_raddr(rw_raddr), .o_rdata(rw_rdata));
    scc_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_renum (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata));
    scc_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_labels (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(l_raddr), .o_rdata(l_rdata));

    // edge under test, oriented by pass
    logic [VW-1:0] w_from, w_to;
    assign w_from = r_pass2 ? e_rdata[2*VW-1:VW] : e_rdata[VW-1:0];
    assign w_to   = r_pass2 ? e_rdata[VW-1:0]    : e_rdata[2*VW-1:VW];

    logic w_edge_ok;
    assign w_edge_ok = (w_from == r_top_v) && (w_to != '0) && (w_to <= w_n) &&
                       (w_from <= w_n) && !r_visited[AW'(w_to - VW'(1))];

    logic [DW-1:0] w_depth_m1, w_depth_m2;
    assign w_depth_m1 = r_depth - DW'(1);
    assign w_depth_m2 = r_depth - DW'(2);

    logic [DW-1:0] w_fin_m1;
    assign w_fin_m1 = r_finished - DW'(1);

    logic w_add_bad, w_q_bad;
    assign w_add_bad = (w_tail == '0) || (w_tail > w_n) || (w_head == '0) ||
                       (w_head > w_n) || (r_edges == EW'(MAX_EDGES));
    assign w_q_bad   = (w_qv == '0) || (w_qv > w_n);

    logic w_p2_ok;
    assign w_p2_ok = (f_rdata != '0) && (f_rdata <= w_n) &&
                     !r_visited[AW'(f_rdata - VW'(1))];

    // RAM port selection
    always_comb begin
        e_we = 1'b0; e_waddr = r_edges[EAW-1:0]; e_wdata = {w_head, w_tail};
        e_raddr = r_top_j[EAW-1:0];
        s_we = 1'b0; s_waddr = w_depth_m1[AW-1:0];
        s_wdata = {r_top_v, r_top_j + EW'(1)};
        s_raddr = w_depth_m2[AW-1:0];
        f_we = 1'b0; f_waddr = r_finished[AW-1:0]; f_wdata = r_top_v;
        f_raddr = w_fin_m1[AW-1:0];
        rw_we = 1'b0; rw_waddr = AW'(w_to - VW'(1)); rw_wdata = r_count[LW-1:0];
        rw_raddr = r_rn_i[AW-1:0];
        m_we = 1'b0; m_waddr = AW'(r_raw); m_wdata = r_next_id[LW-1:0];
        m_raddr = AW'(rw_rdata);
        l_we = 1'b0; l_waddr = r_rn_i[AW-1:0]; l_wdata = '0;
        l_raddr = AW'(w_qv - VW'(1));
        case (r_state)
            scc_pkg::ST_IDLE: begin
                e_we = w_accept && (w_op == scc_pkg::OP_ADD) && !w_add_bad;
            end
            scc_pkg::ST_EDGE_RD: begin
                f_we = (r_top_j >= r_edges) && !r_pass2;
            end
            scc_pkg::ST_EDGE_CHK: begin
                s_we  = w_edge_ok;
                rw_we = w_edge_ok && r_pass2;
            end
            scc_pkg::ST_P2_CHK: begin
                rw_we    = w_p2_ok;
                rw_waddr = AW'(f_rdata - VW'(1));
            end
            scc_pkg::ST_RN_RD: begin
                l_we = (r_rn_i != DW'(MAX_VERTICES)) &&
                       !(int'(r_rn_i) < int'(w_n));
            end
            scc_pkg::ST_RN_WR: begin
                m_we = !r_renumd[AW'(r_raw)];
                l_we = 1'b1;
                l_wdata = r_renumd[AW'(r_raw)] ? m_rdata : r_next_id[LW-1:0];
            end
            default: begin
            end
        endcase
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scc_pkg::ST_IDLE;
            r_vc        <= '0;
            r_edges     <= '0;
            r_total     <= '0;
            r_ran       <= 1'b0;
            r_out_valid <= 1'b0;
            r_pass2     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_vc <= i_cfg_data;
            end
            if (m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                scc_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_out_id    <= '0;
                        r_out_total <= r_total;
                        r_out_err   <= 1'b0;
                        case (w_op)
                            scc_pkg::OP_ADD: begin
                                r_out_valid <= 1'b1;
                                r_out_err   <= w_add_bad;
                                if (!w_add_bad) begin
                                    r_edges <= r_edges + EW'(1);
                                end
                            end
                            scc_pkg::OP_RUN: begin
                                // start forward pass
                                r_visited  <= '0;
                                r_pass2    <= 1'b0;
                                r_i        <= (VW+1)'(1);
                                r_finished <= '0;
                                r_state    <= scc_pkg::ST_P1_OUTER;
                            end
                            scc_pkg::OP_QUERY: begin
                                if (w_q_bad) begin
                                    r_out_valid <= 1'b1;
                                    r_out_err   <= 1'b1;
                                end else begin
                                    r_state <= scc_pkg::ST_QUERY;
                                end
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                                r_out_err   <= 1'b1;
                            end
                        endcase
                    end
                end
                scc_pkg::ST_QUERY: begin
                    r_out_valid <= 1'b1;
                    r_out_id    <= r_ran ? l_rdata : '0;
                    r_state     <= scc_pkg::ST_IDLE;
                end
                scc_pkg::ST_P1_OUTER: begin
                    if (r_i > {1'b0, w_n}) begin
                        // forward pass done: clear marks, walk finish order back
                        r_visited <= '0;
                        r_pass2   <= 1'b1;
                        r_count   <= '0;
                        r_state   <= scc_pkg::ST_P2_RD;
                    end else begin
                        r_i <= r_i + (VW+1)'(1);
                        if (!r_visited[AW'(r_i - (VW+1)'(1))]) begin
                            r_visited[AW'(r_i - (VW+1)'(1))] <= 1'b1;
                            r_top_v <= r_i[VW-1:0];
                            r_top_j <= '0;
                            r_depth <= DW'(1);
                            r_state <= scc_pkg::ST_EDGE_RD;
                        end
                    end
                end
                scc_pkg::ST_EDGE_RD: begin
                    if (r_top_j < r_edges) begin
                        r_state <= scc_pkg::ST_EDGE_CHK;
                    end else begin
                        // no more edges out of top: pop it
                        if (!r_pass2) begin
                            r_finished <= r_finished + DW'(1);
                        end
                        r_depth <= w_depth_m1;
                        if (r_depth == DW'(1)) begin
                            if (r_pass2) begin
                                r_count <= r_count + TW'(1);
                                r_state <= scc_pkg::ST_P2_RD;
                            end else begin
                                r_state <= scc_pkg::ST_P1_OUTER;
                            end
                        end else begin
                            r_state <= scc_pkg::ST_POP_LOAD;
                        end
                    end
                end
                scc_pkg::ST_EDGE_CHK: begin
                    if (w_edge_ok) begin
                        // push: frame below gets resume index j+1
                        r_visited[AW'(w_to - VW'(1))] <= 1'b1;
                        r_top_v <= w_to;
                        r_top_j <= '0;
                        r_depth <= r_depth + DW'(1);
                    end else begin
                        r_top_j <= r_top_j + EW'(1);
                    end
                    r_state <= scc_pkg::ST_EDGE_RD;
                end
                scc_pkg::ST_POP_LOAD: begin
                    r_top_v <= s_rdata[SW-1:EW];
                    r_top_j <= s_rdata[EW-1:0];
                    r_state <= scc_pkg::ST_EDGE_RD;
                end
                scc_pkg::ST_P2_RD: begin
                    if (r_finished == '0) begin
                        r_rn_i    <= '0;
                        r_renumd  <= '0;
                        r_next_id <= '0;
                        r_state   <= scc_pkg::ST_RN_RD;
                    end else begin
                        r_finished <= w_fin_m1;
                        r_state    <= scc_pkg::ST_P2_CHK;
                    end
                end
                scc_pkg::ST_P2_CHK: begin
                    if (w_p2_ok) begin
                        r_visited[AW'(f_rdata - VW'(1))] <= 1'b1;
                        r_top_v <= f_rdata;
                        r_top_j <= '0;
                        r_depth <= DW'(1);
                        r_state <= scc_pkg::ST_EDGE_RD;
                    end else begin
                        r_state <= scc_pkg::ST_P2_RD;
                    end
                end
                scc_pkg::ST_RN_RD: begin
                    if (r_rn_i == DW'(MAX_VERTICES)) begin
                        r_state <= scc_pkg::ST_DONE;
                    end else if (int'(r_rn_i) < int'(w_n)) begin
                        r_state <= scc_pkg::ST_RN_MAP;
                    end else begin
                        r_rn_i <= r_rn_i + DW'(1);
                    end
                end
                scc_pkg::ST_RN_MAP: begin
                    r_raw   <= rw_rdata;
                    r_state <= scc_pkg::ST_RN_WR;
                end
                scc_pkg::ST_RN_WR: begin
                    if (!r_renumd[AW'(r_raw)]) begin
                        r_renumd[AW'(r_raw)] <= 1'b1;
                        r_next_id <= r_next_id + TW'(1);
                    end
                    r_rn_i  <= r_rn_i + DW'(1);
                    r_state <= scc_pkg::ST_RN_RD;
                end
                scc_pkg::ST_DONE: begin
                    r_total     <= r_count;
                    r_ran       <= 1'b1;
                    r_out_valid <= 1'b1;
                    r_out_id    <= '0;
                    r_out_total <= r_count;
                    r_out_err   <= 1'b0;
                    r_state     <= scc_pkg::ST_IDLE;
                end
                default: begin
                    r_state <= scc_pkg::ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
